### sv/twrm_pkg.sv
`timescale 1ns / 1ps
package twrm_pkg;

  // Field widths
  localparam int COORD_W = 4;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int ACT_W = 2;

  // Tile coordinates are 4 bits, so no grid side goes past this
  localparam int COORD_LIMIT = 16;

  localparam int DEF_MAX_GRID_X = 16;
  localparam int DEF_MAX_GRID_Y = 16;

  localparam logic [CFG_W-1:0] GRID_RESET = 5'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_UNLOAD = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_NONE = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_FLUSH
  } seq_state_t;

  // One window position handed to the map pipeline
  typedef struct packed {
    logic valid;
    act_t act;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } issue_t;

  // Sequencer to datapath
  typedef struct packed {
    issue_t iss;
    logic flush;
    logic clear;
  } seq_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic adv;
    logic b_busy;
    logic flush_ok;
  } pipe_stat_t;

  // Grid side as used: zero reads as one, capped at the limit
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] v;
    v = (r == '0) ? CFG_W'(1) : r;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] win_lo(input logic [COORD_W-1:0] c);
    return (c != '0) ? c - COORD_W'(1) : '0;
  endfunction

  function automatic logic [COORD_W-1:0] win_hi(input logic [COORD_W-1:0] c,
                                                input logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] cp;
    logic [CFG_W-1:0] sm;
    cp = {1'b0, c} + CFG_W'(1);
    sm = size - CFG_W'(1);
    return (cp < sm) ? cp[COORD_W-1:0] : sm[COORD_W-1:0];
  endfunction

endpackage

### sv/twrm_map_mem.sv
`timescale 1ns / 1ps
module twrm_map_mem import twrm_pkg::*; #(
  parameter int DEPTH = DEF_MAX_GRID_X * DEF_MAX_GRID_Y
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/twrm_seq.sv
`timescale 1ns / 1ps
module twrm_seq import twrm_pkg::*; #(
  parameter int DEPTH = DEF_MAX_GRID_X * DEF_MAX_GRID_Y
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_W-1:0]       new_center_x,
  input  logic [COORD_W-1:0]       new_center_y,
  input  logic [CFG_W-1:0]         w_eff,
  input  logic [CFG_W-1:0]         h_eff,
  input  pipe_stat_t               stat,
  output seq_ctl_t                 ctl,
  output logic [$clog2(DEPTH)-1:0] clr_addr
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  seq_state_t state, state_next;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [COORD_W-1:0] cx, cy;
  logic [COORD_W-1:0] ocx, ocy;
  logic               known;
  logic [COORD_W-1:0] nx0, nx1, ny0, ny1;
  logic [COORD_W-1:0] ox0, ox1, oy0, oy1;
  logic               old_en;
  logic               phase;      // 0: old window, 1: new window
  logic [COORD_W-1:0] px, py;
  logic               iss_on;

  // Bounds from the captured centre
  logic [CFG_W-1:0]   wm1, hm1;
  logic [COORD_W-1:0] ncx, ncy;
  logic [COORD_W-1:0] s_nx0, s_nx1, s_ny0, s_ny1;
  logic [COORD_W-1:0] s_ox0, s_ox1, s_oy0, s_oy1;
  logic               s_old_ok;

  always_comb begin
    wm1 = w_eff - CFG_W'(1);
    hm1 = h_eff - CFG_W'(1);
    ncx = ({1'b0, cx} > wm1) ? wm1[COORD_W-1:0] : cx;
    ncy = ({1'b0, cy} > hm1) ? hm1[COORD_W-1:0] : cy;
    s_nx0 = win_lo(ncx);
    s_nx1 = win_hi(ncx, w_eff);
    s_ny0 = win_lo(ncy);
    s_ny1 = win_hi(ncy, h_eff);
    s_ox0 = win_lo(ocx);
    s_ox1 = win_hi(ocx, w_eff);
    s_oy0 = win_lo(ocy);
    s_oy1 = win_hi(ocy, h_eff);
    // old window can be empty after the grid shrinks
    s_old_ok = known && (s_ox0 <= s_ox1) && (s_oy0 <= s_oy1);
  end

  // Current position against both windows
  logic               in_new, in_old, cand;
  logic [COORD_W-1:0] x1, y0, y1;

  always_comb begin
    in_new = (nx0 <= px) && (px <= nx1) && (ny0 <= py) && (py <= ny1);
    in_old = old_en && (ox0 <= px) && (px <= ox1) && (oy0 <= py) && (py <= oy1);
    cand = phase ? !in_old : !in_new;
    x1 = phase ? nx1 : ox1;
    y0 = phase ? ny0 : oy0;
    y1 = phase ? ny1 : oy1;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!iss_on && !stat.b_busy) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.flush_ok) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = 1'b1;
    ctl = '0;
    case (state)
      S_CLEAR: ctl.clear = 1'b1;
      S_IDLE:  in_stall = 1'b0;
      S_WALK: begin
        ctl.iss.valid = iss_on && cand;
        ctl.iss.act = phase ? ACT_LOAD : ACT_UNLOAD;
        ctl.iss.x = px;
        ctl.iss.y = py;
      end
      S_FLUSH: ctl.flush = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign clr_addr = clr_cnt;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      known <= 1'b0;
      ocx <= '0;
      ocy <= '0;
      iss_on <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (state == S_SETUP) iss_on <= 1'b1;
      if (state == S_WALK && stat.adv && iss_on && py == y1 && px == x1 && phase) begin
        iss_on <= 1'b0;
      end
      if (state == S_FLUSH && stat.flush_ok) begin
        ocx <= cx;
        ocy <= cy;
        known <= 1'b1;
      end
    end
  end

  // Window bounds and walk counters
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cx <= new_center_x;
          cy <= new_center_y;
        end
      end
      S_SETUP: begin
        cx <= ncx;
        cy <= ncy;
        nx0 <= s_nx0;
        nx1 <= s_nx1;
        ny0 <= s_ny0;
        ny1 <= s_ny1;
        ox0 <= s_ox0;
        ox1 <= s_ox1;
        oy0 <= s_oy0;
        oy1 <= s_oy1;
        old_en <= s_old_ok;
        phase <= !s_old_ok;
        px <= s_old_ok ? s_ox0 : s_nx0;
        py <= s_old_ok ? s_oy0 : s_ny0;
      end
      S_WALK: begin
        if (stat.adv && iss_on) begin
          if (py != y1) begin
            py <= py + COORD_W'(1);
          end else if (px != x1) begin
            py <= y0;
            px <= px + COORD_W'(1);
          end else if (!phase) begin
            phase <= 1'b1;
            px <= nx0;
            py <= ny0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/tile_window_residency_manager.sv
`timescale 1ns / 1ps
// Output: each result word is held until the next is found; the last word leaves
// with the flush.
// Input: a new centre is taken only once the previous one is flushed; the walk waits
// only while the output is full and stalled.
// Reset: clears the map by a sweep of all MAX_GRID_X*MAX_GRID_Y (clipped to 16 each)
// entries, 256 by default, with input stalled; config resets to a 4x4 grid.
module tile_window_residency_manager import twrm_pkg::*; #(
  parameter int MAX_GRID_X = DEF_MAX_GRID_X,
  parameter int MAX_GRID_Y = DEF_MAX_GRID_Y
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   new_center_x,
  input  logic [COORD_W-1:0]   new_center_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ACT_W-1:0]     action,
  output logic [COORD_W-1:0]   tile_x,
  output logic [COORD_W-1:0]   tile_y,
  output logic                 last
);

  localparam int EFF_X = (MAX_GRID_X < COORD_LIMIT) ? MAX_GRID_X : COORD_LIMIT;
  localparam int EFF_Y = (MAX_GRID_Y < COORD_LIMIT) ? MAX_GRID_Y : COORD_LIMIT;
  localparam int DEPTH = EFF_X * EFF_Y;
  localparam int ADDR_W = $clog2(DEPTH);

  // Config registers
  logic [CFG_W-1:0] grid_width, grid_height;
  logic [CFG_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign w_eff = eff_size(grid_width, CFG_W'(EFF_X));
  assign h_eff = eff_size(grid_height, CFG_W'(EFF_Y));

  seq_ctl_t          ctl;
  pipe_stat_t        stat;
  logic [ADDR_W-1:0] clr_addr;

  twrm_seq #(.DEPTH(DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .new_center_x (new_center_x),
    .new_center_y (new_center_y),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .stat         (stat),
    .ctl          (ctl),
    .clr_addr     (clr_addr)
  );

  // Map read stage: position whose map bit arrives this cycle
  logic               b_valid;
  act_t               b_act;
  logic [COORD_W-1:0] b_x, b_y;

  // Held result, sent once the next one (or the end) is known
  logic               pend_valid;
  act_t               pend_act;
  logic [COORD_W-1:0] pend_x, pend_y;

  logic              rd_data;
  logic              hit, out_free, adv, push_pend, flush_fire;
  logic              mem_we, mem_wdata;
  logic [ADDR_W-1:0] rd_addr, b_addr, mem_waddr;

  always_comb begin
    rd_addr = ADDR_W'(ctl.iss.x) * ADDR_W'(EFF_Y) + ADDR_W'(ctl.iss.y);
    b_addr = ADDR_W'(b_x) * ADDR_W'(EFF_Y) + ADDR_W'(b_y);
    out_free = !out_valid || !out_stall;
    hit = b_valid && ((b_act == ACT_UNLOAD) ? rd_data : !rd_data);
    adv = !(hit && pend_valid && !out_free);
    push_pend = adv && hit && pend_valid;
    flush_fire = ctl.flush && out_free;
    mem_we = ctl.clear || (adv && hit);
    mem_waddr = ctl.clear ? clr_addr : b_addr;
    mem_wdata = !ctl.clear && (b_act == ACT_LOAD);
    stat.adv = adv;
    stat.b_busy = b_valid;
    stat.flush_ok = out_free;
  end

  twrm_map_mem #(.DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read stage and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (adv) b_valid <= ctl.iss.valid;
      if (adv && hit) pend_valid <= 1'b1;
      else if (flush_fire) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_act <= ctl.iss.act;
      b_x <= ctl.iss.x;
      b_y <= ctl.iss.y;
    end
    if (adv && hit) begin
      pend_act <= b_act;
      pend_x <= b_x;
      pend_y <= b_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend || flush_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      action <= pend_act;
      tile_x <= pend_x;
      tile_y <= pend_y;
      last <= 1'b0;
    end else if (flush_fire) begin
      action <= pend_valid ? pend_act : ACT_NONE;
      tile_x <= pend_valid ? pend_x : '0;
      tile_y <= pend_valid ? pend_y : '0;
      last <= 1'b1;
    end
  end

  // Nothing left in flight once a new word can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !pend_valid && !b_valid)
    else $error("work in flight while taking a new word");

  // A walk write always flips the bit it just read
  a_flip: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !ctl.clear) |-> (mem_wdata != rd_data))
    else $error("map write does not flip the bit");

  // The walk only waits on a full, stalled output
  a_wait: assert property (@(posedge clk) disable iff (rst)
    !adv |-> pend_valid && out_valid && out_stall)
    else $error("walk held without cause");

  // A nothing result stands alone
  a_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_NONE) |-> last && tile_x == '0 && tile_y == '0)
    else $error("nothing result malformed");

endmodule
